@@ design/pota_pkg.sv @@
// Package with the shared widths, register indexes and reset values of the assist torque unit.
`timescale 1ns / 1ps
`default_nettype none
package pota_pkg;

  localparam int GAIN_W   = 16;
  localparam int RATIO_W  = 4;
  localparam int MOTOR_W  = 8;
  localparam int THR_W    = 19;
  localparam int GSEL_W   = GAIN_W + RATIO_W;
  localparam int QUOT_W   = 20;
  localparam int TORQUE_W = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 19;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = 2;

  localparam logic [QUOT_W-1:0] TORQUE_POS_MAX = 20'd524287;
  localparam logic [QUOT_W-1:0] TORQUE_NEG_MAX = 20'd524288;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ASSIST_GAIN   = 3'd0,
    REG_RIGHT_RATIO   = 3'd1,
    REG_RIGHT_MOTOR   = 3'd2,
    REG_ANGLE_LOW     = 3'd3,
    REG_VEL_THR       = 3'd4,
    REG_ANGLE_SAFETY  = 3'd5
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0]  RST_ASSIST_GAIN  = 16'd6554;
  localparam logic [RATIO_W-1:0] RST_RIGHT_RATIO  = 4'd3;
  localparam logic [MOTOR_W-1:0] RST_RIGHT_MOTOR  = 8'd2;
  localparam logic [THR_W-1:0]   RST_ANGLE_LOW    = 19'd512;
  localparam logic [THR_W-1:0]   RST_VEL_THR      = 19'd256;
  localparam logic [THR_W-1:0]   RST_ANGLE_SAFETY = 19'd12800;

  // Handshake between the queue and its neighbors.
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

@@ design/pota_front.sv @@
// Front part: configuration registers, magnitude, gating and gain selection per word.
`timescale 1ns / 1ps
`default_nettype none
module pota_front
  import pota_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 20
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [SAMPLE_WIDTH-1:0]    joint_angle,
  input  wire logic [SAMPLE_WIDTH-1:0]    joint_velocity,
  input  wire logic [MOTOR_W-1:0]         motor_number,
  input  wire q_stat_t                    q_stat,
  output logic                            q_push,
  output logic [2*SAMPLE_WIDTH+GSEL_W+1:0] q_data
);

  localparam int W = SAMPLE_WIDTH;

  logic [GAIN_W-1:0]  gain_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [MOTOR_W-1:0] rmotor_r;
  logic [THR_W-1:0]   alow_r, vthr_r, asafe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r   <= RST_ASSIST_GAIN;
      ratio_r  <= RST_RIGHT_RATIO;
      rmotor_r <= RST_RIGHT_MOTOR;
      alow_r   <= RST_ANGLE_LOW;
      vthr_r   <= RST_VEL_THR;
      asafe_r  <= RST_ANGLE_SAFETY;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ASSIST_GAIN:  gain_r   <= cfg_wdata[GAIN_W-1:0];
        REG_RIGHT_RATIO:  ratio_r  <= cfg_wdata[RATIO_W-1:0];
        REG_RIGHT_MOTOR:  rmotor_r <= cfg_wdata[MOTOR_W-1:0];
        REG_ANGLE_LOW:    alow_r   <= cfg_wdata[THR_W-1:0];
        REG_VEL_THR:      vthr_r   <= cfg_wdata[THR_W-1:0];
        REG_ANGLE_SAFETY: asafe_r  <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [W-1:0]      a_mag, v_mag;
  logic              wneg, gated;
  logic [W+THR_W-1:0] a_ext, v_ext;
  logic [GSEL_W-1:0] gsel;

  always_comb begin
    a_mag = joint_angle[W-1] ? (~joint_angle + 1'b1) : joint_angle;
    v_mag = joint_velocity[W-1] ? (~joint_velocity + 1'b1) : joint_velocity;
    wneg  = joint_velocity[W-1];
    a_ext = {{THR_W{1'b0}}, a_mag};
    v_ext = {{THR_W{1'b0}}, v_mag};
    gated = (a_ext < {{W{1'b0}}, alow_r}) || (v_ext < {{W{1'b0}}, vthr_r}) ||
            (a_ext > {{W{1'b0}}, asafe_r});
    if (motor_number == rmotor_r) begin
      gsel = {{RATIO_W{1'b0}}, gain_r} * {{GAIN_W{1'b0}}, ratio_r};
    end else begin
      gsel = {{RATIO_W{1'b0}}, gain_r};
    end
  end

  logic fv_r;
  logic [2*W+GSEL_W+1:0] fdata_r;

  assign q_push   = fv_r && !q_stat.full;
  assign in_ready = !fv_r || !q_stat.full;
  assign q_data   = fdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_ready) begin
      fv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      fdata_r <= {gated, wneg, gsel, v_mag, a_mag};
    end
  end

endmodule
`default_nettype wire

@@ design/pota_queue.sv @@
// Short queue between the front and the back part.
`timescale 1ns / 1ps
`default_nettype none
module pota_queue
  import pota_pkg::*;
#(
  parameter int DATA_W = 62
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire q_ctrl_t           q_ctrl,
  output q_stat_t                q_stat,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic [DATA_W-1:0]      rd_data
);

  logic [DATA_W-1:0] mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;

  assign q_stat.full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign rd_data      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (q_ctrl.push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (q_ctrl.push) wp_r <= wp_r + 1'b1;
      if (q_ctrl.pop)  rp_r <= rp_r + 1'b1;
      if (q_ctrl.push && !q_ctrl.pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!q_ctrl.push && q_ctrl.pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/pota_back.sv @@
// Back part: squares, pipelined square root, pipelined divider and output saturation.
`timescale 1ns / 1ps
`default_nettype none
module pota_back
  import pota_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 20
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire q_stat_t                     q_stat,
  output logic                             q_pop,
  input  wire logic [2*SAMPLE_WIDTH+GSEL_W+1:0] q_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [TORQUE_W-1:0]              assist_torque,
  output logic                             assist_gated,
  output logic                             torque_saturated
);

  localparam int W    = SAMPLE_WIDTH;
  localparam int SQ0  = 3;
  localparam int ND   = SQ0 + W;
  localparam int DV0  = ND + 1;
  localparam int LAST = DV0 + QUOT_W - 1;
  localparam int NST  = LAST + 1;

  typedef struct packed {
    logic [W-1:0]        a;
    logic [W-1:0]        v;
    logic [GSEL_W-1:0]   g;
    logic                wneg;
    logic                gated;
    logic [2*W-1:0]      aa;
    logic [2*W-1:0]      vv;
    logic [2*W-1:0]      s;
    logic [W+GSEL_W-1:0] vg;
    logic [W+2:0]        rem;
    logic [W-1:0]        root;
    logic [W:0]          drem;
    logic [QUOT_W-1:0]   nlo;
    logic [QUOT_W-1:0]   q;
  } stg_t;

  stg_t stg_r   [NST];
  stg_t stg_nxt [NST];
  logic [NST-1:0] vld_r;

  logic adv;
  logic ov_r;
  assign adv   = !ov_r || out_ready;
  assign q_pop = adv && !q_stat.empty;

  always_comb begin
    logic [W+2:0]        trem;
    logic [W+2:0]        test;
    logic [W:0]          tdiv;
    logic [W+GSEL_W:0]   n;
    stg_t p;
    trem = '0;
    test = '0;
    tdiv = '0;
    n    = '0;
    p    = stg_r[0];

    // Stage 0 loads the queue head and squares the angle.
    stg_nxt[0]       = stg_r[0];
    stg_nxt[0].a     = q_data[W-1:0];
    stg_nxt[0].v     = q_data[2*W-1:W];
    stg_nxt[0].g     = q_data[2*W+GSEL_W-1:2*W];
    stg_nxt[0].wneg  = q_data[2*W+GSEL_W];
    stg_nxt[0].gated = q_data[2*W+GSEL_W+1];
    stg_nxt[0].aa    = {{W{1'b0}}, q_data[W-1:0]} * {{W{1'b0}}, q_data[W-1:0]};

    stg_nxt[1]    = stg_r[0];
    stg_nxt[1].vv = {{W{1'b0}}, stg_r[0].v} * {{W{1'b0}}, stg_r[0].v};

    stg_nxt[2]      = stg_r[1];
    stg_nxt[2].s    = stg_r[1].aa + stg_r[1].vv;
    stg_nxt[2].vg   = {{GSEL_W{1'b0}}, stg_r[1].v} * {{W{1'b0}}, stg_r[1].g};
    stg_nxt[2].rem  = '0;
    stg_nxt[2].root = '0;

    // One root bit per stage from the top pair of the radicand.
    for (int k = 0; k < W; k++) begin
      p    = stg_r[SQ0+k-1];
      trem = {p.rem[W:0], p.s[2*W-1:2*W-2]};
      test = {1'b0, p.root, 2'b01};
      stg_nxt[SQ0+k]   = p;
      stg_nxt[SQ0+k].s = {p.s[2*W-3:0], 2'b00};
      if (trem >= test) begin
        stg_nxt[SQ0+k].rem  = trem - test;
        stg_nxt[SQ0+k].root = {p.root[W-2:0], 1'b1};
      end else begin
        stg_nxt[SQ0+k].rem  = trem;
        stg_nxt[SQ0+k].root = {p.root[W-2:0], 1'b0};
      end
    end

    // Add half the divisor so the quotient rounds half up.
    p = stg_r[ND-1];
    n = {1'b0, p.vg} + {{(GSEL_W+1){1'b0}}, p.root >> 1};
    stg_nxt[ND]      = p;
    stg_nxt[ND].drem = n[W+GSEL_W:QUOT_W];
    stg_nxt[ND].nlo  = n[QUOT_W-1:0];
    stg_nxt[ND].q    = '0;

    // The quotient stays below 2^20, so twenty restoring steps cover it.
    for (int k = 0; k < QUOT_W; k++) begin
      p    = stg_r[DV0+k-1];
      tdiv = {p.drem[W-1:0], p.nlo[QUOT_W-1]};
      stg_nxt[DV0+k]     = p;
      stg_nxt[DV0+k].nlo = {p.nlo[QUOT_W-2:0], 1'b0};
      if (tdiv >= {1'b0, p.root}) begin
        stg_nxt[DV0+k].drem = tdiv - {1'b0, p.root};
        stg_nxt[DV0+k].q    = {p.q[QUOT_W-2:0], 1'b1};
      end else begin
        stg_nxt[DV0+k].drem = tdiv;
        stg_nxt[DV0+k].q    = {p.q[QUOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], q_pop};
    end
  end

  logic [QUOT_W-1:0]   mag;
  logic [QUOT_W-1:0]   mclip;
  logic                sat;
  logic [TORQUE_W-1:0] tq;

  always_comb begin
    // A zero root means both samples were zero: the torque is zero.
    mag = (stg_r[LAST].root == '0) ? '0 : stg_r[LAST].q;
    if (stg_r[LAST].wneg) begin
      sat   = mag > TORQUE_NEG_MAX;
      mclip = sat ? TORQUE_NEG_MAX : mag;
      tq    = ~mclip + 1'b1;
    end else begin
      sat   = mag > TORQUE_POS_MAX;
      mclip = sat ? TORQUE_POS_MAX : mag;
      tq    = mclip;
    end
    if (stg_r[LAST].gated) begin
      sat = 1'b0;
      tq  = '0;
    end
  end

  logic [TORQUE_W-1:0] torque_r;
  logic                gated_r, sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= vld_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      torque_r <= tq;
      gated_r  <= stg_r[LAST].gated;
      sat_r    <= sat;
    end
  end

  assign out_valid        = ov_r;
  assign assist_torque    = torque_r;
  assign assist_gated     = gated_r;
  assign torque_saturated = sat_r;

endmodule
`default_nettype wire

@@ design/phase_oscillator_assist_torque_unit.sv @@
// Top level of the phase oscillator assist torque unit.
//
//  Channel | Direction | Payload
//  in_     | slave     | tdata: joint_angle, joint_velocity, motor_number
//  out_    | master    | tdata: assist_torque, assist_gated, torque_saturated
//  cfg_    | write     | cfg_index selects the register, cfg_wdata holds the value
//
// One word is accepted per cycle unless the queue and front stage are full; the latency is set
// by the one-bit-per-stage square root and the twenty-stage divider.
// Reset is synchronous and active low; it clears valid bits and loads register defaults.
// A stalled output freezes the back pipeline; the four-entry queue and front stage
// keep accepting words until they fill.
`timescale 1ns / 1ps
`default_nettype none
module phase_oscillator_assist_torque_unit
  import pota_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // joint_angle, joint_velocity, motor_number, zero fill
  input  wire logic [((2*SAMPLE_WIDTH+MOTOR_W+7)/8)*8-1:0] in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // assist_torque, assist_gated, torque_saturated, zero fill
  output logic [23:0]                 out_tdata
);

  localparam int W    = SAMPLE_WIDTH;
  localparam int QD_W = 2*W + GSEL_W + 2;

  q_stat_t          q_stat;
  q_ctrl_t          q_ctrl;
  logic             q_push, q_pop;
  logic [QD_W-1:0]  q_wr, q_rd;
  logic [TORQUE_W-1:0] torque;
  logic             gated, sat;

  assign q_ctrl = '{push: q_push, pop: q_pop};

  pota_front #(.SAMPLE_WIDTH(W)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .joint_angle    (in_tdata[W-1:0]),
    .joint_velocity (in_tdata[2*W-1:W]),
    .motor_number   (in_tdata[2*W+MOTOR_W-1:2*W]),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_data         (q_wr)
  );

  pota_queue #(.DATA_W(QD_W)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_ctrl  (q_ctrl),
    .q_stat  (q_stat),
    .wr_data (q_wr),
    .rd_data (q_rd)
  );

  pota_back #(.SAMPLE_WIDTH(W)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_pop            (q_pop),
    .q_data           (q_rd),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .assist_torque    (torque),
    .assist_gated     (gated),
    .torque_saturated (sat)
  );

  assign out_tdata = {2'b00, sat, gated, torque};

endmodule
`default_nettype wire

@@ design/pota_checker.sv @@
// Port-level checker for the assist torque unit and its bind.
`timescale 1ns / 1ps
`default_nettype none
module pota_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output word changed while stalled");

  a_gated_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[20] |-> (out_tdata[19:0] == 20'd0) && !out_tdata[21])
    else $error("gated word carries torque");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21] |->
      (out_tdata[19:0] == 20'h7FFFF) || (out_tdata[19:0] == 20'h80000))
    else $error("saturated word is not at a range limit");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind phase_oscillator_assist_torque_unit pota_checker u_pota_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

@@ tb/phase_oscillator_assist_torque_unit_tb.sv @@
// Self-checking testbench for the phase oscillator assist torque unit.
`timescale 1ns / 1ps
module phase_oscillator_assist_torque_unit_tb;
  import pota_pkg::*;

  localparam int SW = 20;
  localparam int IN_W = ((2*SW+MOTOR_W+7)/8)*8;
  localparam int LATENCY = SW + 26;

  typedef struct packed {
    logic [TORQUE_W-1:0] torque;
    logic gated;
    logic sat;
  } torque_word_t;

  typedef struct {
    logic [SW-1:0] angle;
    logic [SW-1:0] vel;
    logic [MOTOR_W-1:0] motor;
    logic check_fixed;
    torque_word_t fixed;
  } stim_row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_wr_en = 0;
  cfg_reg_t cfg_index = REG_ASSIST_GAIN;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [23:0] out_tdata;

  // Predictor copy of the register file.
  logic [GAIN_W-1:0] gain_q;
  logic [RATIO_W-1:0] ratio_q;
  logic [MOTOR_W-1:0] right_q;
  logic [THR_W-1:0] low_q, vthr_q, safe_q;

  torque_word_t torque_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;

  phase_oscillator_assist_torque_unit #(.SAMPLE_WIDTH(SW)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] s);
    logic [63:0] root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic torque_word_t assist_torque(input logic [SW-1:0] angle,
      input logic [SW-1:0] vel, input logic [MOTOR_W-1:0] motor);
    torque_word_t res;
    logic [63:0] a, v, g, r, m;
    logic [SW-1:0] am, vm;
    logic wneg;
    am = angle[SW-1] ? ((~angle) + 1'b1) : angle;
    wneg = vel[SW-1];
    vm = wneg ? ((~vel) + 1'b1) : vel;
    a = 64'(am);
    v = 64'(vm);
    res = '0;
    if (a < low_q || v < vthr_q || a > safe_q) begin
      res.gated = 1;
    end else begin
      g = gain_q;
      if (motor == right_q) g = g * ratio_q;
      r = int_sqrt(a * a + v * v);
      m = (r != 0) ? (v * g + (r >> 1)) / r : 0;
      if (wneg) begin
        if (m > TORQUE_NEG_MAX) begin
          m = TORQUE_NEG_MAX;
          res.sat = 1;
        end
        res.torque = TORQUE_W'((~m) + 1);
      end else begin
        if (m > TORQUE_POS_MAX) begin
          m = TORQUE_POS_MAX;
          res.sat = 1;
        end
        res.torque = TORQUE_W'(m);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
      input logic [31:0] want);
    errors++;
    $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 0;
    case (idx)
      REG_ASSIST_GAIN: gain_q = val[GAIN_W-1:0];
      REG_RIGHT_RATIO: ratio_q = val[RATIO_W-1:0];
      REG_RIGHT_MOTOR: right_q = val[MOTOR_W-1:0];
      REG_ANGLE_LOW: low_q = val[THR_W-1:0];
      REG_VEL_THR: vthr_q = val[THR_W-1:0];
      REG_ANGLE_SAFETY: safe_q = val[THR_W-1:0];
      default: ;
    endcase
  endtask

  // Holds a word on the input until it is taken; expectation is queued on acceptance.
  // Valid stays high past acceptance so back-to-back words leave no gap.
  task automatic send_word(input logic [SW-1:0] angle, input logic [SW-1:0] vel,
      input logic [MOTOR_W-1:0] motor, input logic use_fixed, input torque_word_t fixed);
    torque_word_t pred;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= IN_W'({motor, vel, angle});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = assist_torque(angle, vel, motor);
    if (use_fixed && pred != fixed) report_mismatch("table entry", fixed, pred);
    torque_q.push_back(use_fixed ? fixed : pred);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    torque_word_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{torque: out_tdata[TORQUE_W-1:0], gated: out_tdata[TORQUE_W],
              sat: out_tdata[TORQUE_W+1]};
      if (torque_q.size() == 0) begin
        report_mismatch("unexpected word", got, 0);
      end else begin
        want = torque_q.pop_front();
        if (got.torque !== want.torque) report_mismatch("assist_torque", got.torque, want.torque);
        if (got.gated !== want.gated) report_mismatch("assist_gated", got.gated, want.gated);
        if (got.sat !== want.sat) report_mismatch("torque_saturated", got.sat, want.sat);
      end
    end
  end

  task automatic drain;
    int guard;
    guard = 0;
    in_tvalid <= 0;
    while (torque_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [SW-1:0] rand_sample(input int mode);
    logic [SW-1:0] s;
    case (mode)
      0: s = SW'($urandom);
      1: s = SW'($urandom_range(15000));
      default: s = SW'(-$signed(SW'($urandom_range(15000))));
    endcase
    return s;
  endfunction

  stim_row_t rows[$];
  localparam logic [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};

  initial begin
    int phase;
    gain_q = RST_ASSIST_GAIN; ratio_q = RST_RIGHT_RATIO; right_q = RST_RIGHT_MOTOR;
    low_q = RST_ANGLE_LOW; vthr_q = RST_VEL_THR; safe_q = RST_ANGLE_SAFETY;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed table: gated rows, the default right motor, and the extremes.
    rows = '{
      '{angle: 0, vel: 0, motor: 0, check_fixed: 1, fixed: '{0, 1, 0}},
      '{angle: SMIN, vel: SMAX, motor: 0, check_fixed: 1, fixed: '{0, 1, 0}},
      '{angle: 1024, vel: 100, motor: 0, check_fixed: 1, fixed: '{0, 1, 0}},
      '{angle: 20000, vel: 1024, motor: 0, check_fixed: 1, fixed: '{0, 1, 0}},
      '{angle: 1024, vel: 1024, motor: 0, check_fixed: 0, fixed: '0},
      '{angle: -1024, vel: -1024, motor: 2, check_fixed: 0, fixed: '0},
      '{angle: 512, vel: SMAX, motor: 2, check_fixed: 0, fixed: '0},
      '{angle: 12800, vel: SMIN, motor: 255, check_fixed: 0, fixed: '0},
      '{angle: -12800, vel: 256, motor: 2, check_fixed: 0, fixed: '0}
    };
    foreach (rows[i]) send_word(rows[i].angle, rows[i].vel, rows[i].motor,
                                rows[i].check_fixed, rows[i].fixed);
    drain();

    // Zero thresholds with the origin, then extreme gain to force clipping.
    write_reg(REG_ANGLE_LOW, 0);
    write_reg(REG_VEL_THR, 0);
    write_reg(REG_ANGLE_SAFETY, {THR_W{1'b1}});
    write_reg(REG_ASSIST_GAIN, 16'hFFFF);
    write_reg(REG_RIGHT_RATIO, 4'hF);
    write_reg(REG_RIGHT_MOTOR, 8'd255);
    send_word(0, 0, 0, 1, '{0, 0, 0});
    send_word(0, SMAX, 255, 1, '{TORQUE_POS_MAX, 0, 1});
    send_word(0, SMIN, 255, 1, '{TORQUE_NEG_MAX, 0, 1});
    send_word(SMAX, SMIN, 7, 0, '0);
    send_word(SMIN, 1, 255, 0, '0);
    drain();
    write_reg(REG_RIGHT_RATIO, 0);
    send_word(1000, 1000, 255, 0, '0);
    send_word(1000, -1000, 0, 0, '0);
    drain();

    for (phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 27 : (phase == 1) ? 47 : 0;
      recv_idle = (phase == 0) ? 47 : (phase == 1) ? 27 : 0;
      write_reg(REG_ASSIST_GAIN, $urandom_range(65535));
      write_reg(REG_RIGHT_RATIO, $urandom_range(15));
      write_reg(REG_RIGHT_MOTOR, $urandom_range(3));
      write_reg(REG_ANGLE_LOW, (phase == 2) ? 0 : $urandom_range(800));
      write_reg(REG_VEL_THR, (phase == 2) ? 0 : $urandom_range(600));
      write_reg(REG_ANGLE_SAFETY, (phase == 1) ? {THR_W{1'b1}} : $urandom_range(8000, 20000));
      repeat (630) begin
        // Mostly samples near the active window, some full-range noise.
        send_word(rand_sample($urandom_range(3) == 0 ? 0 : $urandom_range(1, 2)),
                  rand_sample($urandom_range(3) == 0 ? 0 : $urandom_range(1, 2)),
                  MOTOR_W'($urandom_range(7) == 0 ? $urandom : $urandom_range(3)), 0, '0);
      end
      drain();
    end

    if (errors == 0 && torque_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
